// ----- design/color_keyed_sprite_blitter_defines.svh -----
// assertion macros shared by the checker files
// clock aclk and active-low reset aresetn are taken from the enclosing scope
`ifndef COLOR_KEYED_SPRITE_BLITTER_DEFINES_SVH
`define COLOR_KEYED_SPRITE_BLITTER_DEFINES_SVH

// same-cycle implication
`define CKB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ckb: property violated");

// next-cycle implication
`define CKB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ckb: property violated");

`endif

// ----- design/ckb_pkg.sv -----
`timescale 1ns / 1ps

package ckb_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam logic [10:0] FRAME_W_LIM = 11'(FRAME_WIDTH);
    localparam logic [10:0] FRAME_H_LIM = 11'(FRAME_HEIGHT);

    // pixel and scaling constants
    localparam logic [31:0] ALPHA_MASK = 32'hff00_0000;
    localparam logic [6:0]  PERCENT    = 7'd100;

    // divide by 100 as multiply by reciprocal, exact for products below 2^18
    localparam int          PROD_W       = 18;
    localparam int          DIV100_W     = 19;
    localparam logic [DIV100_W-1:0] DIV100_MUL = 19'd335545;
    localparam int          DIV100_SHIFT = 25;
    localparam int          DIV_PROD_W   = PROD_W + DIV100_W;

    // front to back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // register file
    localparam int APB_ADDR_W = 5;
    localparam logic [2:0] REG_COLOR_KEY     = 3'd0;
    localparam logic [2:0] REG_DRAW_MODE     = 3'd1;
    localparam logic [2:0] REG_OFFSET_X      = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd3;
    localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd5;
    localparam logic [2:0] REG_DRAW_RATE     = 3'd6;

    // draw modes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_TINT  = 2'd1;
    localparam logic [1:0] MODE_BLEND = 2'd2;
    localparam logic [1:0] MODE_RAW   = 2'd3;

    // reset values
    localparam logic [31:0] RST_COLOR_KEY = 32'hffff_ffff;
    localparam logic [6:0]  RST_DRAW_RATE = 7'd100;

    typedef struct packed {
        logic [31:0] color_key;
        logic [1:0]  draw_mode;
        logic [11:0] offset_x;
        logic [11:0] offset_y;
        logic [10:0] sprite_width;
        logic [10:0] sprite_height;
        logic [6:0]  draw_rate;
    } cfg_t;

    // what the back end does with a pixel
    typedef enum logic [2:0] {
        OP_KEEP,
        OP_COPY,
        OP_TINT,
        OP_BLEND,
        OP_RAW
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  frame_x;
        logic [9:0]  frame_y;
        logic [31:0] src_pixel;
        logic [31:0] frame_pixel;
        logic        last_pixel;
    } rec_t;

endpackage

// ----- design/ckb_regs.sv -----
`timescale 1ns / 1ps

module ckb_regs import ckb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_key     <= RST_COLOR_KEY;
            cfg_reg.draw_mode     <= MODE_COPY;
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.sprite_width  <= '0;
            cfg_reg.sprite_height <= '0;
            cfg_reg.draw_rate     <= RST_DRAW_RATE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COLOR_KEY:     cfg_reg.color_key     <= pwdata;
                REG_DRAW_MODE:     cfg_reg.draw_mode     <= pwdata[1:0];
                REG_OFFSET_X:      cfg_reg.offset_x      <= pwdata[11:0];
                REG_OFFSET_Y:      cfg_reg.offset_y      <= pwdata[11:0];
                REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= pwdata[10:0];
                REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= pwdata[10:0];
                REG_DRAW_RATE:     cfg_reg.draw_rate     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_COLOR_KEY:     prdata = cfg_reg.color_key;
            REG_DRAW_MODE:     prdata = {30'd0, cfg_reg.draw_mode};
            REG_OFFSET_X:      prdata = {20'd0, cfg_reg.offset_x};
            REG_OFFSET_Y:      prdata = {20'd0, cfg_reg.offset_y};
            REG_SPRITE_WIDTH:  prdata = {21'd0, cfg_reg.sprite_width};
            REG_SPRITE_HEIGHT: prdata = {21'd0, cfg_reg.sprite_height};
            REG_DRAW_RATE:     prdata = {25'd0, cfg_reg.draw_rate};
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- design/ckb_queue.sv -----
`timescale 1ns / 1ps

module ckb_queue import ckb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t push_data,
    output logic full,
    input  logic pop,
    output rec_t pop_data,
    output logic empty
);

    rec_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/ckb_front.sv -----
`timescale 1ns / 1ps

module ckb_front import ckb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_src_col,
    input  logic [9:0]  s_src_row,
    input  logic [31:0] s_src_pixel,
    input  logic [31:0] s_frame_pixel,
    input  logic        s_last_pixel,
    output logic        q_push,
    output rec_t        q_data,
    input  logic        q_full
);

    // true if pos falls inside the clipped extent along one axis
    function automatic logic in_span(input logic [11:0] off, input logic [10:0] full,
                                     input logic [10:0] drawn, input logic [10:0] limit,
                                     input logic [9:0] pos);
        logic signed [14:0] off_s;
        logic signed [14:0] skip;
        logic signed [14:0] d;
        logic signed [14:0] dr;
        logic signed [14:0] span_end;
        logic signed [14:0] lim_s;
        logic signed [14:0] pos_s;
        off_s = 15'($signed(off));
        if (off[11]) begin
            skip = -off_s;
            d    = '0;
        end else begin
            skip = '0;
            d    = off_s;
        end
        dr       = $signed({4'd0, drawn}) - skip;
        span_end = d + $signed({4'd0, full});
        lim_s    = $signed({4'd0, limit});
        if (lim_s < span_end) begin
            dr = dr - (span_end - lim_s);
        end
        pos_s = $signed({5'd0, pos});
        return (pos_s >= skip) && ((pos_s - skip) < dr);
    endfunction

    // stage a: scaled size products
    logic                a_valid_reg, a_valid_next;
    logic [9:0]          a_col_reg, a_row_reg;
    logic [31:0]         a_src_reg, a_frm_reg;
    logic                a_last_reg;
    logic [PROD_W-1:0]   a_wprod_reg, a_hprod_reg;
    // stage b: extents divided by 100
    logic                b_valid_reg, b_valid_next;
    logic [9:0]          b_col_reg, b_row_reg;
    logic [31:0]         b_src_reg, b_frm_reg;
    logic                b_last_reg;
    logic [10:0]         b_rw_reg, b_rh_reg;

    logic                a_ready, b_ready, a_adv, b_adv, s_adv;
    logic [6:0]          rate_clamped;
    logic [DIV_PROD_W-1:0] w_mul, h_mul;
    logic [10:0]         rh_eff;
    logic                in_x, in_y, in_win, keyed;
    logic [31:0]         p_opaque;
    op_t                 op;

    // elastic handshake through the two stages
    assign b_adv   = b_valid_reg && !q_full;
    assign b_ready = !b_valid_reg || b_adv;
    assign a_adv   = a_valid_reg && b_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign s_adv   = s_valid && a_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ready) begin
            a_valid_next = s_valid;
        end
        b_valid_next = b_valid_reg;
        if (b_ready) begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // rate above one hundred counts as one hundred
    assign rate_clamped = (cfg.draw_rate > PERCENT) ? PERCENT : cfg.draw_rate;

    always_ff @(posedge aclk) begin
        if (s_adv) begin
            a_col_reg   <= s_src_col;
            a_row_reg   <= s_src_row;
            a_src_reg   <= s_src_pixel;
            a_frm_reg   <= s_frame_pixel;
            a_last_reg  <= s_last_pixel;
            a_wprod_reg <= PROD_W'(cfg.sprite_width) * PROD_W'(rate_clamped);
            a_hprod_reg <= PROD_W'(cfg.sprite_height) * PROD_W'(rate_clamped);
        end
    end

    // reciprocal multiply for the divide by 100
    assign w_mul = DIV_PROD_W'(a_wprod_reg) * DIV_PROD_W'(DIV100_MUL);
    assign h_mul = DIV_PROD_W'(a_hprod_reg) * DIV_PROD_W'(DIV100_MUL);

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_col_reg  <= a_col_reg;
            b_row_reg  <= a_row_reg;
            b_src_reg  <= a_src_reg;
            b_frm_reg  <= a_frm_reg;
            b_last_reg <= a_last_reg;
            b_rw_reg   <= w_mul[DIV100_SHIFT +: 11];
            b_rh_reg   <= h_mul[DIV100_SHIFT +: 11];
        end
    end

    // clip window and colour key
    assign rh_eff   = (cfg.draw_mode == MODE_RAW) ? b_rh_reg : cfg.sprite_height;
    assign in_x     = in_span(cfg.offset_x, cfg.sprite_width, b_rw_reg, FRAME_W_LIM, b_col_reg);
    assign in_y     = in_span(cfg.offset_y, cfg.sprite_height, rh_eff, FRAME_H_LIM, b_row_reg);
    assign in_win   = in_x && in_y;
    assign p_opaque = b_src_reg | ALPHA_MASK;
    assign keyed    = (p_opaque == cfg.color_key);

    always_comb begin
        op = OP_KEEP;
        if (in_win) begin
            case (cfg.draw_mode)
                MODE_RAW:   op = OP_RAW;
                MODE_COPY:  op = keyed ? OP_KEEP : OP_COPY;
                MODE_TINT:  op = keyed ? OP_KEEP : OP_TINT;
                MODE_BLEND: op = keyed ? OP_KEEP : OP_BLEND;
                default:    op = OP_KEEP;
            endcase
        end
    end

    // classified beat into the queue
    assign q_push              = b_adv;
    assign q_data.op           = op;
    assign q_data.frame_x      = in_win ? (cfg.offset_x[9:0] + b_col_reg) : '0;
    assign q_data.frame_y      = in_win ? (cfg.offset_y[9:0] + b_row_reg) : '0;
    assign q_data.src_pixel    = b_src_reg;
    assign q_data.frame_pixel  = b_frm_reg;
    assign q_data.last_pixel   = b_last_reg;

endmodule

// ----- design/ckb_back.sv -----
`timescale 1ns / 1ps

module ckb_back import ckb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  rec_t        q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [9:0]  m_frame_x,
    output logic [9:0]  m_frame_y,
    output logic [31:0] m_out_pixel,
    output logic        m_done_res
);

    logic        m_valid_reg, m_valid_next;
    logic        we_reg;
    logic [9:0]  fx_reg, fy_reg;
    logic [31:0] pix_reg;
    logic        done_reg;
    logic [31:0] p_opaque, blend, pix_next;
    logic [8:0]  byte_sum;

    // take the next beat whenever the output register is free or drains
    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // per-channel average for half blend
    assign p_opaque = q_data.src_pixel | ALPHA_MASK;

    always_comb begin
        blend    = '0;
        byte_sum = '0;
        for (int i = 0; i < 4; i++) begin
            byte_sum       = {1'b0, p_opaque[8*i +: 8]} + {1'b0, q_data.frame_pixel[8*i +: 8]};
            blend[8*i +: 8] = byte_sum[8:1];
        end
    end

    // pixel to store
    always_comb begin
        case (q_data.op)
            OP_KEEP:  pix_next = q_data.frame_pixel;
            OP_COPY:  pix_next = p_opaque;
            OP_TINT:  pix_next = {p_opaque[31:16], 1'b0, p_opaque[15:9], 1'b0, p_opaque[7:1]};
            OP_BLEND: pix_next = blend;
            OP_RAW:   pix_next = q_data.src_pixel;
            default:  pix_next = q_data.frame_pixel;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            we_reg   <= (q_data.op != OP_KEEP);
            fx_reg   <= q_data.frame_x;
            fy_reg   <= q_data.frame_y;
            pix_reg  <= pix_next;
            done_reg <= q_data.last_pixel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_write_enable = we_reg;
    assign m_frame_x      = fx_reg;
    assign m_frame_y      = fy_reg;
    assign m_out_pixel    = pix_reg;
    assign m_done_res     = done_reg;

endmodule

// ----- design/color_keyed_sprite_blitter.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake         | beat contents
// ---------+-----------+-------------------+---------------------------------------------
// s_       | in        | s_valid / s_ready | sprite col, row, sprite pixel, frame pixel, last
// m_       | out       | m_valid / m_ready | write enable, frame x, frame y, pixel, done
// apb      | in        | psel/penable      | seven registers at byte addresses 0 to 24
//
// one pixel a cycle sustained while neither side stalls; an input beat passes in order through
// the rate multiply stage, the reciprocal divide stage, the queue and the output register
// the front stalls only when the queue is full, the back only when m_ready is low
// synchronous active-low reset clears the pipeline valid flags, empties the queue and returns the registers to defaults

module color_keyed_sprite_blitter import ckb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [9:0]            s_src_col,
    input  logic [9:0]            s_src_row,
    input  logic [31:0]           s_src_pixel,
    input  logic [31:0]           s_frame_pixel,
    input  logic                  s_last_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_enable,
    output logic [9:0]            m_frame_x,
    output logic [9:0]            m_frame_y,
    output logic [31:0]           m_out_pixel,
    output logic                  m_done_res
);

    cfg_t cfg;
    rec_t q_in, q_out;
    logic q_push, q_full, q_pop, q_empty;

    assign pready = 1'b1;

    // configuration registers
    ckb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // scaling and classification
    ckb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_col     (s_src_col),
        .s_src_row     (s_src_row),
        .s_src_pixel   (s_src_pixel),
        .s_frame_pixel (s_frame_pixel),
        .s_last_pixel  (s_last_pixel),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    // decoupling queue
    ckb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // pixel operation and output register
    ckb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_frame_x      (m_frame_x),
        .m_frame_y      (m_frame_y),
        .m_out_pixel    (m_out_pixel),
        .m_done_res     (m_done_res)
    );

endmodule

// ----- design/ckb_checker.sv -----
`timescale 1ns / 1ps
`include "color_keyed_sprite_blitter_defines.svh"

module ckb_checker import ckb_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_write_enable,
    input logic [9:0]            m_frame_x,
    input logic [9:0]            m_frame_y,
    input logic [31:0]           m_out_pixel,
    input logic                  m_done_res
);

    localparam logic [APB_ADDR_W-1:0] ADDR_COLOR_KEY = {REG_COLOR_KEY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_DRAW_RATE = {REG_DRAW_RATE, 2'b00};

    logic        cfg_wr;
    logic [53:0] out_beat;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_beat = {m_write_enable, m_frame_x, m_frame_y, m_out_pixel, m_done_res};

    // a stalled output beat stays
    `CKB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)

    // and keeps its payload
    `CKB_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(out_beat))

    // colour key reads back as written
    `CKB_ASSERT_NEXT(a_key_readback, cfg_wr && (paddr == ADDR_COLOR_KEY) && $stable(paddr), prdata == $past(pwdata))

    // draw rate keeps its low seven bits only
    `CKB_ASSERT_NEXT(a_rate_readback, cfg_wr && (paddr == ADDR_DRAW_RATE) && $stable(paddr), prdata == {25'd0, $past(pwdata[6:0])})

endmodule

bind color_keyed_sprite_blitter ckb_checker u_ckb_checker (.*);
